FILE: sv/bsp_pkg.sv
// ============================================================================
// bsp_pkg
// Shared types and constants for the bounded stack with peek and change.
// ============================================================================
`default_nettype none

package bsp_pkg;

    localparam int WORD_W   = 32;
    localparam int POS_W    = 8;
    localparam int COUNT_W  = 8;

    // Data word returned on every error and after push and change.
    localparam logic [WORD_W-1:0] ERR_WORD = '1;

    typedef enum logic [1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_PEEK   = 2'd2,
        ACT_CHANGE = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_ABSENT   = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
        logic change;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/bounded_stack_with_peek_change_top.sv
// ============================================================================
// bounded_stack_with_peek_change_top
// Bounded stack of 32-bit words with push, pop, peek and change by position.
// ============================================================================
//
//   Channel   Direction  Handshake            Payload
//   s_        in         s_valid / s_ready    s_action, s_value, s_position
//   m_        out        m_valid / m_ready    m_data, m_status, m_count
//
// Each request is executed in the cycle it is accepted and its response is
// registered, so one request per cycle is sustained while m_ready stays high.
// The stack is a chain of DEPTH cells that shift together on push and pop;
// peek and change address a cell by comparing the position in every cell.
// Reset (aresetn low, synchronous) empties the stack and drops any pending
// response; cell contents are not cleared and are never read before written.
// When m_ready is low with a response held, s_ready falls until it is taken.
// ============================================================================
`default_nettype none

module bounded_stack_with_peek_change_top #(
    parameter int DEPTH = 128
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic        [1:0]                 s_action,
    input  wire logic signed [bsp_pkg::WORD_W-1:0] s_value,
    input  wire logic        [bsp_pkg::POS_W-1:0]  s_position,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed      [bsp_pkg::WORD_W-1:0] m_data,
    output logic             [1:0]                 m_status,
    output logic             [bsp_pkg::COUNT_W-1:0] m_count
);
    import bsp_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    // Entry count and response register.
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               m_valid_reg;
    logic               m_valid_next;
    logic [WORD_W-1:0]  data_reg;
    logic [WORD_W-1:0]  data_next;
    status_t            status_reg;
    status_t            status_next;

    logic               accept;
    action_t            action;
    logic               full;
    logic               empty;
    logic               pos_ok;
    cell_ctrl_t         ctrl;

    // Cell contents and per-cell read ports of the chain.
    logic [WORD_W-1:0]  cell_data [DEPTH];
    logic [WORD_W-1:0]  cell_rd   [DEPTH];
    logic [WORD_W-1:0]  read_word;
    logic [31:0]        count_wide;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign action  = action_t'(s_action);

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    // A position is present when it lies between one and the entry count.
    assign pos_ok = (s_position != '0) && (32'(s_position) <= 32'(count_reg));

    // Command broadcast to the cells; only successful operations move data.
    always_comb begin
        ctrl        = '0;
        ctrl.push   = accept && (action == ACT_PUSH) && !full;
        ctrl.pop    = accept && (action == ACT_POP) && !empty;
        ctrl.change = accept && (action == ACT_CHANGE) && pos_ok;
    end

    // The chain: cell 0 takes the pushed word, the last cell refills with
    // a don't-care zero on pop.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] upper;
        logic [WORD_W-1:0] lower;

        if (i == 0) begin : g_first
            assign upper = s_value;
        end else begin : g_mid_up
            assign upper = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign lower = '0;
        end else begin : g_mid_down
            assign lower = cell_data[i+1];
        end

        bsp_cell #(
            .INDEX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .position  (s_position),
            .value     (s_value),
            .upper_data(upper),
            .lower_data(lower),
            .data_out  (cell_data[i]),
            .rd_out    (cell_rd[i])
        );
    end

    // At most one cell matches the position, so its word is an OR of all
    // read ports.
    always_comb begin
        read_word = '0;
        for (int i = 0; i < DEPTH; i++) begin
            read_word = read_word | cell_rd[i];
        end
    end

    // Response and count for the accepted request.
    always_comb begin
        count_next   = count_reg;
        data_next    = data_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (accept) begin
            m_valid_next = 1'b1;
            data_next    = ERR_WORD;
            status_next  = ST_OK;
            unique case (action)
                ACT_PUSH: begin
                    if (full) begin
                        status_next = ST_OVERFLOW;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                ACT_POP: begin
                    if (empty) begin
                        status_next = ST_EMPTY;
                    end else begin
                        count_next = count_reg - CNT_W'(1);
                        data_next  = cell_data[0];
                    end
                end
                ACT_PEEK: begin
                    if (pos_ok) begin
                        data_next = read_word;
                    end else begin
                        status_next = ST_ABSENT;
                    end
                end
                ACT_CHANGE: begin
                    if (!pos_ok) begin
                        status_next = ST_ABSENT;
                    end
                end
                default: begin
                    status_next = ST_ABSENT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg   <= data_next;
        status_reg <= status_next;
    end

    // The count field reports the low bits of the entry count, which is
    // zero-extended first when the stack is shallow.
    assign count_wide = 32'(count_reg);

    assign m_valid  = m_valid_reg;
    assign m_data   = data_reg;
    assign m_status = status_reg;
    assign m_count  = count_wide[COUNT_W-1:0];

endmodule

`default_nettype wire

FILE: sv/bsp_cell.sv
// ============================================================================
// bsp_cell
// One storage cell of the stack chain; cell 0 holds the top entry.
// ============================================================================
`default_nettype none

module bsp_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                       aclk,
    input  wire bsp_pkg::cell_ctrl_t        ctrl,
    input  wire logic [bsp_pkg::POS_W-1:0]  position,
    input  wire logic [bsp_pkg::WORD_W-1:0] value,
    input  wire logic [bsp_pkg::WORD_W-1:0] upper_data,
    input  wire logic [bsp_pkg::WORD_W-1:0] lower_data,
    output logic      [bsp_pkg::WORD_W-1:0] data_out,
    output logic      [bsp_pkg::WORD_W-1:0] rd_out
);
    import bsp_pkg::*;

    // Position counted from the top that addresses this cell.
    localparam int  SLOT      = INDEX + 1;
    localparam bit  REACHABLE = (SLOT < (1 << POS_W));

    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] data_next;
    logic              hit;

    assign hit = REACHABLE && (position == POS_W'(SLOT));

    // Push moves every entry one cell down, pop one cell up; change writes the value into the addressed cell.
    always_comb begin
        data_next = data_reg;
        if (ctrl.push) begin
            data_next = upper_data;
        end else if (ctrl.pop) begin
            data_next = lower_data;
        end else if (ctrl.change && hit) begin
            data_next = value;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign rd_out   = hit ? data_reg : '0;

endmodule

`default_nettype wire

FILE: sv/bsp_checker.sv
// ============================================================================
// bsp_checker
// Port-level checks for the bounded stack, attached to the top level by bind.
// ============================================================================
`default_nettype none

module bsp_checker #(
    parameter int DEPTH = 128
) (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic signed [bsp_pkg::WORD_W-1:0] m_data,
    input wire logic        [1:0]                 m_status,
    input wire logic        [bsp_pkg::COUNT_W-1:0] m_count
);
    import bsp_pkg::*;

    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    // A response is valid in the cycle after an accepted request.
    a_resp_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> m_valid)
        else $error("no response after accepted request");

    // Every error carries the error word.
    a_err_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != ST_OK)) |-> (m_data == ERR_WORD))
        else $error("error response without error word");

    // Overflow happens only with a full stack, empty only with no entries.
    a_err_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_status != ST_OVERFLOW) || (m_count == FULL_COUNT))
                 && ((m_status != ST_EMPTY) || (m_count == '0)))
        else $error("status inconsistent with count");

    // A stalled response holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)
                                   && $stable(m_status) && $stable(m_count)))
        else $error("stalled response changed");

endmodule

bind bounded_stack_with_peek_change_top bsp_checker #(
    .DEPTH(DEPTH)
) u_bsp_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_data    (m_data),
    .m_status  (m_status),
    .m_count   (m_count)
);

`default_nettype wire

FILE: tb/sv/tb_bounded_stack_with_peek_change_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_bounded_stack_with_peek_change_top
// Self-checking testbench for the bounded stack with peek and change.
// A shadow stack predicts the response to every accepted request, and each
// response is compared field by field with the oldest prediction. Directed
// corner cases come first, then a full fill and drain, then random traffic
// under several idle and stall patterns, and finally a long receiver hold-off.
// ============================================================================

module tb_bounded_stack_with_peek_change_top;

    import bsp_pkg::*;

    localparam int STACK_DEPTH = 128;
    localparam int CYCLE_LIMIT = 200000;
    // The response is registered; the run waits out SETTLE_CYCLES at the end
    // to catch any stray response.
    localparam int SETTLE_CYCLES = 10;

    typedef struct packed {
        logic [WORD_W-1:0]  data;
        status_t            status;
        logic [COUNT_W-1:0] count;
    } stack_response_t;

    // Clock, reset and all block inputs start at known values.
    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    action_t s_action = ACT_PUSH;
    logic signed [WORD_W-1:0] s_value = '0;
    logic [POS_W-1:0] s_position = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [WORD_W-1:0] m_data;
    logic [1:0] m_status;
    logic [COUNT_W-1:0] m_count;

    // Shadow copy of the stack used for prediction, updated at acceptance.
    logic [WORD_W-1:0] shadow_words [STACK_DEPTH];
    int shadow_count = 0;
    stack_response_t pending_responses [$];

    // Depth that the stimulus side believes the stack will have once every
    // request sent so far is executed. It only steers position choices.
    int stim_depth = 0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_cycles_left = 0;

    int cycle_count = 0;
    int mismatch_count = 0;
    int action_seen [4] = '{default: 0};
    int status_seen [4] = '{default: 0};
    int deepest_count = 0;
    int stalled_input_cycles = 0;

    bounded_stack_with_peek_change_top #(
        .DEPTH(STACK_DEPTH)
    ) uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_value   (s_value),
        .s_position(s_position),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .m_status  (m_status),
        .m_count   (m_count)
    );

    // 4 ns clock period.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog. A run that hangs on a handshake ends here as a failure.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Run stopped: cycle limit of %0d reached.", CYCLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Works out the response to one request and moves the shadow stack on.
    // Position counts from the top, so position 1 is the newest entry.
    function automatic stack_response_t predict_stack_response(
        input action_t act, input logic [WORD_W-1:0] word, input logic [POS_W-1:0] position
    );
        stack_response_t resp;
        resp.data = ERR_WORD;
        resp.status = ST_OK;
        case (act)
            ACT_PUSH: begin
                if (shadow_count >= STACK_DEPTH) begin
                    resp.status = ST_OVERFLOW;
                end else begin
                    shadow_words[shadow_count] = word;
                    shadow_count++;
                end
            end
            ACT_POP: begin
                if (shadow_count == 0) begin
                    resp.status = ST_EMPTY;
                end else begin
                    shadow_count--;
                    resp.data = shadow_words[shadow_count];
                end
            end
            ACT_PEEK: begin
                if (position == 0 || int'(position) > shadow_count) begin
                    resp.status = ST_ABSENT;
                end else begin
                    resp.data = shadow_words[shadow_count - int'(position)];
                end
            end
            default: begin
                // A change writes the word but still reports the error word.
                if (position == 0 || int'(position) > shadow_count) begin
                    resp.status = ST_ABSENT;
                end else begin
                    shadow_words[shadow_count - int'(position)] = word;
                end
            end
        endcase
        resp.count = shadow_count[COUNT_W-1:0];
        return resp;
    endfunction

    // Monitor. Both channels are sampled at the rising edge, before any
    // nonblocking update of that edge lands. The response is checked before
    // the request of the same edge is predicted, because a response always
    // belongs to an earlier request.
    always @(posedge aclk) begin : monitor
        stack_response_t want;
        if (aresetn) begin
            if (s_valid && !s_ready) begin
                stalled_input_cycles++;
            end
            if (m_valid && m_ready) begin
                if (pending_responses.size() == 0) begin
                    $error("Response with no request outstanding: data %0d status %0d count %0d",
                           m_data, m_status, m_count);
                    mismatch_count++;
                end else begin
                    want = pending_responses.pop_front();
                    if (m_data !== want.data) begin
                        $error("m_data mismatch: expected %0d, actual %0d",
                               $signed(want.data), m_data);
                        mismatch_count++;
                    end
                    if (m_status !== want.status) begin
                        $error("m_status mismatch: expected %0d, actual %0d",
                               want.status, m_status);
                        mismatch_count++;
                    end
                    if (m_count !== want.count) begin
                        $error("m_count mismatch: expected %0d, actual %0d",
                               want.count, m_count);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                want = predict_stack_response(s_action, s_value, s_position);
                pending_responses.push_back(want);
                action_seen[s_action]++;
                status_seen[want.status]++;
                if (shadow_count > deepest_count) begin
                    deepest_count = shadow_count;
                end
            end
        end
    end

    // Receiver. A hold-off requested by a test keeps m_ready low for that
    // many cycles; otherwise m_ready drops at random at the stall rate.
    always @(posedge aclk) begin
        if (hold_cycles_left > 0) begin
            m_ready <= 1'b0;
            hold_cycles_left = hold_cycles_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Sends one request. An optional idle gap comes first; valid is only
    // lowered when a gap is actually taken, so back-to-back requests keep it
    // high. The task returns at the edge where the request is accepted.
    task automatic send_request(
        input action_t act, input logic [WORD_W-1:0] word, input logic [POS_W-1:0] position
    );
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_action <= act;
        s_value <= word;
        s_position <= position;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        if (act == ACT_PUSH && stim_depth < STACK_DEPTH) begin
            stim_depth++;
        end else if (act == ACT_POP && stim_depth > 0) begin
            stim_depth--;
        end
    endtask

    // Moves past the current edge first, so the monitor has recorded the
    // last accepted request before the queue is looked at.
    task automatic wait_for_responses();
        @(posedge aclk);
        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Mostly random words, with the extremes mixed in now and then.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(15))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly positions that hit a held entry; the rest are zero, just past
    // the bottom, or anywhere in the 8-bit range.
    function automatic logic [POS_W-1:0] pick_position();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80 && stim_depth > 0) begin
            return POS_W'($urandom_range(stim_depth, 1));
        end else if (roll < 85) begin
            return '0;
        end else if (roll < 90) begin
            return POS_W'(stim_depth + 1);
        end
        return POS_W'($urandom_range(255, 0));
    endfunction

    // Corner cases on a nearly empty stack: every action, the extreme words,
    // positions zero, top, bottom, just past the bottom and the largest one.
    task automatic test_directed_corners();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_request(ACT_POP, pick_word(), 8'd0);
        send_request(ACT_PEEK, pick_word(), 8'd1);
        send_request(ACT_CHANGE, 32'h1234_5678, 8'd1);
        send_request(ACT_PUSH, 32'h7FFF_FFFF, 8'd0);
        send_request(ACT_PUSH, 32'h8000_0000, 8'd255);
        send_request(ACT_PUSH, 32'h0000_0000, 8'd0);
        send_request(ACT_PUSH, 32'hFFFF_FFFF, 8'd0);
        send_request(ACT_PEEK, 32'h0, 8'd0);
        send_request(ACT_PEEK, 32'h0, 8'd1);
        send_request(ACT_PEEK, 32'h0, 8'd4);
        send_request(ACT_PEEK, 32'h0, 8'd5);
        send_request(ACT_PEEK, 32'h0, 8'd255);
        send_request(ACT_CHANGE, 32'h5555_5555, 8'd0);
        send_request(ACT_CHANGE, 32'h5555_5555, 8'd2);
        send_request(ACT_CHANGE, 32'hAAAA_AAAA, 8'd4);
        send_request(ACT_CHANGE, 32'hAAAA_AAAA, 8'd5);
        send_request(ACT_CHANGE, 32'hAAAA_AAAA, 8'd128);
        send_request(ACT_PEEK, 32'h0, 8'd2);
        send_request(ACT_PEEK, 32'h0, 8'd4);
        repeat (4) send_request(ACT_POP, 32'h0, 8'd0);
        send_request(ACT_POP, 32'h0, 8'd0);
        s_valid <= 1'b0;
        wait_for_responses();
    endtask

    // Fills the stack to the brim, pushes into a full stack, works the
    // deepest position, then drains it and pops once more when empty.
    task automatic test_fill_and_drain();
        sender_idle_pct = 38;
        receiver_stall_pct = 38;
        repeat (STACK_DEPTH) send_request(ACT_PUSH, pick_word(), pick_position());
        repeat (3) send_request(ACT_PUSH, pick_word(), pick_position());
        send_request(ACT_PEEK, pick_word(), 8'(STACK_DEPTH));
        send_request(ACT_PEEK, pick_word(), 8'(STACK_DEPTH + 1));
        send_request(ACT_CHANGE, pick_word(), 8'(STACK_DEPTH));
        send_request(ACT_PEEK, pick_word(), 8'(STACK_DEPTH));
        send_request(ACT_CHANGE, pick_word(), 8'd1);
        send_request(ACT_CHANGE, pick_word(), 8'd255);
        send_request(ACT_PEEK, pick_word(), 8'd1);
        repeat (STACK_DEPTH) send_request(ACT_POP, pick_word(), pick_position());
        send_request(ACT_POP, pick_word(), pick_position());
        s_valid <= 1'b0;
        wait_for_responses();
    endtask

    // Random traffic in segments that lean toward filling, draining or
    // neither, so the depth wanders over the whole range.
    task automatic test_random_traffic(input int items, input int idle_pct, input int stall_pct);
        int segment_left;
        int push_weight;
        int pop_weight;
        int roll;
        action_t act;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        segment_left = 0;
        push_weight = 35;
        pop_weight = 35;
        for (int i = 0; i < items; i++) begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(40, 10);
                case ($urandom_range(2))
                    0: begin
                        push_weight = 65;
                        pop_weight = 10;
                    end
                    1: begin
                        push_weight = 10;
                        pop_weight = 65;
                    end
                    default: begin
                        push_weight = 35;
                        pop_weight = 35;
                    end
                endcase
            end
            segment_left--;
            roll = $urandom_range(99);
            if (roll < push_weight) begin
                act = ACT_PUSH;
            end else if (roll < push_weight + pop_weight) begin
                act = ACT_POP;
            end else if (roll[0]) begin
                act = ACT_PEEK;
            end else begin
                act = ACT_CHANGE;
            end
            send_request(act, pick_word(), pick_position());
        end
        s_valid <= 1'b0;
        wait_for_responses();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering requests back to back, so the held response blocks the input.
    task automatic test_receiver_hold();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        @(negedge aclk);
        hold_cycles_left = 300;
        @(posedge aclk);
        repeat (12) send_request(ACT_PUSH, pick_word(), pick_position());
        repeat (6) send_request(ACT_PEEK, pick_word(), pick_position());
        repeat (6) send_request(ACT_CHANGE, pick_word(), pick_position());
        repeat (8) send_request(ACT_POP, pick_word(), pick_position());
        s_valid <= 1'b0;
        wait_for_responses();
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_fill_and_drain();
        test_random_traffic(35, 0, 0);
        test_random_traffic(30, 72, 0);
        test_random_traffic(30, 0, 72);
        test_random_traffic(35, 38, 38);
        test_receiver_hold();

        wait_for_responses();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (pending_responses.size() != 0) begin
            $error("%0d responses never arrived", pending_responses.size());
            mismatch_count++;
        end

        $display("Ran %0d requests (push %0d, pop %0d, peek %0d, change %0d), deepest %0d of %0d.",
                 action_seen[0] + action_seen[1] + action_seen[2] + action_seen[3],
                 action_seen[ACT_PUSH], action_seen[ACT_POP], action_seen[ACT_PEEK],
                 action_seen[ACT_CHANGE], deepest_count, STACK_DEPTH);
        $display("Status: ok %0d, overflow %0d, empty %0d, absent %0d; input stalled %0d cycles.",
                 status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_EMPTY],
                 status_seen[ST_ABSENT], stalled_input_cycles);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
